// ===== rtl/dlrf_pkg.sv =====
// ----------------------------------------------------------------------------
// dlrf_pkg
// Shared types and constants for the dark line run finder.
// ----------------------------------------------------------------------------
package dlrf_pkg;

    localparam int COLUMNS     = 80;
    localparam int COL_W       = $clog2(COLUMNS + 1);
    localparam int PIX_W       = 8;
    localparam int POS_W       = 8;
    localparam int COUNT_W     = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [POS_W-1:0]   EDGE_COLUMN = POS_W'(COLUMNS - 1);
    localparam logic [POS_W-1:0]   NO_COLUMN   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    localparam logic [PIX_W-1:0]   THRESHOLD_RESET = PIX_W'(128);
    localparam logic [COUNT_W-1:0] LIMIT_RESET     = COUNT_W'(5);

    localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH_LIMIT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_CHECK,
        PH_TRACK,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [PIX_W-1:0]   dark_threshold;
        logic [COUNT_W-1:0] run_length_limit;
    } t_cfg;

    typedef struct packed {
        t_phase           phase;
        logic [POS_W-1:0] run_begin;
        logic [POS_W-1:0] run_finish;
    } t_run_info;

endpackage

// ===== rtl/dlrf_cfg.sv =====
// ----------------------------------------------------------------------------
// dlrf_cfg
// Configuration register file written through the configuration channel.
// ----------------------------------------------------------------------------
module dlrf_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [dlrf_pkg::CFG_IDX_W-1:0]   i_index,
    input  logic [dlrf_pkg::CFG_DATA_W-1:0]  i_data,
    output dlrf_pkg::t_cfg                   o_cfg
);
    import dlrf_pkg::*;

    logic [PIX_W-1:0]   r_threshold;
    logic [COUNT_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_limit     <= LIMIT_RESET;
        end else if (i_wr_en) begin
            case (i_index)
                CFG_DARK_THRESHOLD: begin
                    r_threshold <= i_data[PIX_W-1:0];
                end
                CFG_RUN_LENGTH_LIMIT: begin
                    r_limit <= i_data[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = '{dark_threshold: r_threshold, run_length_limit: r_limit};

endmodule

// ===== rtl/dlrf_scan.sv =====
// ----------------------------------------------------------------------------
// dlrf_scan
// Per-pixel run tracking state machine with column counter.
// ----------------------------------------------------------------------------
module dlrf_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [dlrf_pkg::PIX_W-1:0]   i_pixel,
    input  logic                         i_row_last,
    input  dlrf_pkg::t_cfg               i_cfg,
    output dlrf_pkg::t_run_info          o_info
);
    import dlrf_pkg::*;

    t_phase             r_phase;
    logic [POS_W-1:0]   r_begin;
    logic [POS_W-1:0]   r_finish;
    logic [COUNT_W-1:0] r_count;
    logic [COL_W-1:0]   r_column;

    t_phase             n_phase;
    logic [POS_W-1:0]   n_begin;
    logic [POS_W-1:0]   n_finish;
    logic [COUNT_W-1:0] n_count;
    logic [COL_W-1:0]   n_column;

    logic               w_in_row;
    logic               w_dark;
    logic               w_bright;
    logic [COUNT_W-1:0] w_count_inc;
    logic [POS_W-1:0]   w_col_pos;

    assign w_in_row    = (r_column < COL_W'(COLUMNS));
    assign w_dark      = (i_pixel < i_cfg.dark_threshold);
    assign w_bright    = (i_pixel > i_cfg.dark_threshold);
    assign w_count_inc = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);
    assign w_col_pos   = POS_W'(r_column);

    always_comb begin
        n_phase = r_phase;
        if (w_in_row) begin
            case (r_phase)
                PH_SEARCH: begin
                    if (w_dark) n_phase = PH_CHECK;
                end
                PH_CHECK: begin
                    if (!w_dark) begin
                        n_phase = PH_SEARCH;
                    end else if (w_count_inc > i_cfg.run_length_limit) begin
                        n_phase = PH_TRACK;
                    end
                end
                PH_TRACK: begin
                    if (w_bright) n_phase = PH_DONE;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_begin  = r_begin;
        n_finish = r_finish;
        n_count  = r_count;
        n_column = r_column;
        if (w_in_row) begin
            n_column = r_column + COL_W'(1);
            case (r_phase)
                PH_SEARCH: begin
                    if (w_dark) begin
                        n_begin = w_col_pos;
                        n_count = COUNT_W'(1);
                    end
                end
                PH_CHECK: begin
                    if (w_dark) begin
                        n_count = w_count_inc;
                    end else begin
                        n_count = '0;
                        n_begin = NO_COLUMN;
                    end
                end
                PH_TRACK: begin
                    if (w_bright) n_finish = w_col_pos;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEARCH;
            r_begin  <= NO_COLUMN;
            r_finish <= NO_COLUMN;
            r_count  <= '0;
            r_column <= '0;
        end else if (i_accept) begin
            if (i_row_last) begin
                r_phase  <= PH_SEARCH;
                r_begin  <= NO_COLUMN;
                r_finish <= NO_COLUMN;
                r_count  <= '0;
                r_column <= '0;
            end else begin
                r_phase  <= n_phase;
                r_begin  <= n_begin;
                r_finish <= n_finish;
                r_count  <= n_count;
                r_column <= n_column;
            end
        end
    end

    assign o_info = '{phase: n_phase, run_begin: n_begin, run_finish: n_finish};

    a_search_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SEARCH |-> r_begin == NO_COLUMN && r_count == '0)
        else $error("search phase holds a run");

    a_run_has_begin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_SEARCH |-> r_begin != NO_COLUMN)
        else $error("active run without start column");

    a_finish_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_finish != NO_COLUMN) == (r_phase == PH_DONE))
        else $error("end column out of step with phase");

    a_column_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column <= COL_W'(COLUMNS))
        else $error("column counter past row width");

endmodule

// ===== rtl/dlrf_result.sv =====
// ----------------------------------------------------------------------------
// dlrf_result
// Row-end correction, center calculation and output register.
// ----------------------------------------------------------------------------
module dlrf_result (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  dlrf_pkg::t_run_info          i_info,
    input  logic                         i_out_stall,
    output logic                         o_valid,
    output logic [dlrf_pkg::POS_W-1:0]   o_start,
    output logic [dlrf_pkg::POS_W-1:0]   o_end,
    output logic [dlrf_pkg::POS_W-1:0]   o_center
);
    import dlrf_pkg::*;

    logic               r_valid;
    logic [POS_W-1:0]   r_start;
    logic [POS_W-1:0]   r_end;
    logic [POS_W-1:0]   r_center;

    logic [POS_W-1:0]   w_start;
    logic [POS_W-1:0]   w_end;
    logic               w_start_pos;
    logic signed [POS_W:0] w_span;
    logic signed [POS_W:0] w_half;

    assign w_start_pos = !i_info.run_begin[POS_W-1] && (i_info.run_begin != '0);

    always_comb begin
        w_start = i_info.run_begin;
        w_end   = i_info.run_finish;
        if (w_start_pos && i_info.run_finish[POS_W-1]) begin
            if (i_info.phase == PH_TRACK) begin
                w_end = EDGE_COLUMN;
            end else begin
                w_start = NO_COLUMN;
            end
        end
    end

    assign w_span = $signed({w_end[POS_W-1], w_end}) - $signed({w_start[POS_W-1], w_start});
    assign w_half = (w_span + $signed({{POS_W{1'b0}}, w_span[POS_W]})) >>> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_start  <= w_start;
            r_end    <= w_end;
            r_center <= w_start + w_half[POS_W-1:0];
        end
    end

    assign o_valid  = r_valid;
    assign o_start  = r_start;
    assign o_end    = r_end;
    assign o_center = r_center;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !(r_valid && i_out_stall))
        else $error("pending result overwritten");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded result not presented");

    a_open_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_end == NO_COLUMN |-> r_start == NO_COLUMN || r_start == '0)
        else $error("open run with positive start column");

endmodule

// ===== rtl/dark_line_run_finder_core.sv =====
// ----------------------------------------------------------------------------
// dark_line_run_finder_core
// Finds one dark line run per camera row and reports start, end and center.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                        | Payload
//  ---------+----------------------------------+-------------------------------
//  input    | i_in_valid  / o_in_stall         | i_pixel, i_row_last
//  output   | o_out_valid / i_out_stall        | o_line_start, o_line_end,
//           |                                  | o_line_center
//  config   | i_cfg_valid / o_cfg_ready        | i_cfg_index, i_cfg_data
//
// One pixel transaction per cycle while o_in_stall is low; the run state machine is registered.
// A row result appears in the cycle after the row_last transaction.
// The input stalls only when a row_last pixel meets a result held by i_out_stall.
// Synchronous active-low reset restores register defaults and an empty row.
// ----------------------------------------------------------------------------
module dark_line_run_finder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [dlrf_pkg::PIX_W-1:0]        i_pixel,
    input  logic                              i_row_last,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [dlrf_pkg::POS_W-1:0] o_line_start,
    output logic signed [dlrf_pkg::POS_W-1:0] o_line_end,
    output logic signed [dlrf_pkg::POS_W-1:0] o_line_center,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dlrf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dlrf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dlrf_pkg::*;

    t_cfg             w_cfg;
    t_run_info        w_info;
    logic             w_accept;
    logic             w_res_valid;
    logic [POS_W-1:0] w_start;
    logic [POS_W-1:0] w_end;
    logic [POS_W-1:0] w_center;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_res_valid && i_out_stall && i_row_last;
    assign w_accept    = i_in_valid && !o_in_stall;

    dlrf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    dlrf_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_pixel    (i_pixel),
        .i_row_last (i_row_last),
        .i_cfg      (w_cfg),
        .o_info     (w_info)
    );

    dlrf_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept && i_row_last),
        .i_info      (w_info),
        .i_out_stall (i_out_stall),
        .o_valid     (w_res_valid),
        .o_start     (w_start),
        .o_end       (w_end),
        .o_center    (w_center)
    );

    assign o_out_valid   = w_res_valid;
    assign o_line_start  = $signed(w_start);
    assign o_line_end    = $signed(w_end);
    assign o_line_center = $signed(w_center);

endmodule
